// ===== rtl/kpc_pkg.sv =====
`timescale 1ns / 1ps

package kpc_pkg;

    localparam int NUM_KEYS_DEF = 3;

    localparam int PIN_KEYS = 3;
    localparam int ADC_W    = 12;
    localparam int WIN_W    = PIN_KEYS * ADC_W;
    localparam int TICK_W   = 32;
    localparam int SPAN_W   = 31;

    localparam logic [SPAN_W-1:0]   DEBOUNCE_RST    = 31'd20;
    localparam logic [SPAN_W-1:0]   LONG_PRESS_RST  = 31'd1000;
    localparam logic [PIN_KEYS-1:0] LADDER_MASK_RST = 3'd6;
    localparam logic [WIN_W-1:0]    WIN_LOWS_RST    = 36'h0003E8000;
    localparam logic [WIN_W-1:0]    WIN_HIGHS_RST   = 36'h0C8BB8000;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHORT = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;

    typedef enum logic [2:0] {
        CFG_DEBOUNCE    = 3'd0,
        CFG_LONG_PRESS  = 3'd1,
        CFG_LADDER_MASK = 3'd2,
        CFG_WIN_LOWS    = 3'd3,
        CFG_WIN_HIGHS   = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_PRESSING  = 5'b00010,
        PH_PRESSED   = 5'b00100,
        PH_LONG      = 5'b01000,
        PH_RELEASING = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0]   now_ticks;
        logic [PIN_KEYS-1:0] pin_levels;
        logic [ADC_W-1:0]    adc_average;
        logic                adc_valid;
    } t_in_item;

    typedef struct packed {
        logic [1:0] pin_event;
        logic [1:0] pin_event_key;
        logic [1:0] ladder_event;
        logic [1:0] ladder_event_key;
    } t_out_item;

    typedef struct packed {
        logic [SPAN_W-1:0]   debounce_ticks;
        logic [SPAN_W-1:0]   long_press_ticks;
        logic [PIN_KEYS-1:0] ladder_key_mask;
        logic [WIN_W-1:0]    window_lows;
        logic [WIN_W-1:0]    window_highs;
    } t_cfg;

    // scan token handed from cell to cell
    typedef struct packed {
        logic                valid;
        logic [TICK_W-1:0]   now_ticks;
        logic [PIN_KEYS-1:0] pin_levels;
        logic [ADC_W-1:0]    adc_average;
        logic                adc_valid;
        logic                pin_done;
        logic                lad_done;
        t_out_item           res;
    } t_scan;

endpackage

// ===== rtl/kpc_cell.sv =====
`timescale 1ns / 1ps

module kpc_cell
    import kpc_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF,
    parameter int KEY_IDX  = 0,
    localparam int KW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_scan         i_tok,
    input  logic [KW-1:0] i_last,
    output t_scan         o_tok,
    output logic [KW-1:0] o_last
);

    localparam logic [KW-1:0] K_ID  = KW'(KEY_IDX);
    localparam logic [1:0]    K_OUT = 2'(KEY_IDX);

    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_start, n_start;
    t_scan             r_tok, n_tok;
    logic [KW-1:0]     r_last, n_last;

    logic              w_is_lad;
    logic              w_pin_down;
    logic [ADC_W-1:0]  w_lo, w_hi;
    logic              w_in_win;
    logic [TICK_W-1:0] w_db_d, w_lp_d;
    logic              w_db_el, w_lp_el;
    logic              w_step, w_down;
    logic [1:0]        w_ev;

    // keys past the pin field read pressed, are pin keys and have window [0,0]
    generate
        if (KEY_IDX < PIN_KEYS) begin : g_field
            assign w_is_lad   = i_cfg.ladder_key_mask[KEY_IDX];
            assign w_pin_down = ~i_tok.pin_levels[KEY_IDX];
            assign w_lo       = i_cfg.window_lows[KEY_IDX*ADC_W +: ADC_W];
            assign w_hi       = i_cfg.window_highs[KEY_IDX*ADC_W +: ADC_W];
        end else begin : g_nofield
            assign w_is_lad   = 1'b0;
            assign w_pin_down = 1'b1;
            assign w_lo       = '0;
            assign w_hi       = '0;
        end
    endgenerate

    assign w_in_win = (i_tok.adc_average >= w_lo) && (i_tok.adc_average <= w_hi);

    // wrap-aware elapsed test: sign of start + span - now
    assign w_db_d  = r_start + {1'b0, i_cfg.debounce_ticks} - i_tok.now_ticks;
    assign w_lp_d  = r_start + {1'b0, i_cfg.long_press_ticks} - i_tok.now_ticks;
    assign w_db_el = w_db_d[TICK_W-1];
    assign w_lp_el = w_lp_d[TICK_W-1];

    always_comb begin
        n_tok   = i_tok;
        n_last  = i_last;
        n_phase = r_phase;
        n_start = r_start;
        w_step  = 1'b0;
        w_down  = 1'b0;
        w_ev    = EV_NONE;

        if (i_tok.valid) begin
            if (!w_is_lad) begin
                if (!i_tok.pin_done) begin
                    w_step = 1'b1;
                    w_down = w_pin_down;
                end
            end else if (i_tok.adc_valid && !i_tok.lad_done) begin
                // another ladder key came down: take it over and end the ladder scan
                if (w_in_win && (i_last != K_ID)) begin
                    n_last       = K_ID;
                    n_tok.lad_done = 1'b1;
                end else begin
                    w_step = 1'b1;
                    w_down = w_in_win;
                end
            end
        end

        if (w_step) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (w_down) begin
                        n_phase = PH_PRESSING;
                        n_start = i_tok.now_ticks;
                    end
                end
                PH_PRESSING: begin
                    if (w_down && w_db_el) begin
                        n_phase = PH_PRESSED;
                        n_start = i_tok.now_ticks;
                    end
                end
                PH_PRESSED: begin
                    if (w_down) begin
                        if (w_lp_el) begin
                            n_phase = PH_LONG;
                            w_ev    = EV_LONG;
                        end
                    end else begin
                        n_phase = PH_RELEASING;
                        n_start = i_tok.now_ticks;
                    end
                end
                PH_LONG: begin
                    if (!w_down && w_db_el) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_RELEASING: begin
                    if (!w_down && w_db_el) begin
                        n_phase = PH_IDLE;
                        w_ev    = EV_SHORT;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (w_ev != EV_NONE) begin
            if (w_is_lad) begin
                n_tok.lad_done             = 1'b1;
                n_tok.res.ladder_event     = w_ev;
                n_tok.res.ladder_event_key = K_OUT;
            end else begin
                n_tok.pin_done          = 1'b1;
                n_tok.res.pin_event     = w_ev;
                n_tok.res.pin_event_key = K_OUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_start <= '0;
            r_tok   <= '0;
            r_last  <= '0;
        end else begin
            r_phase <= n_phase;
            r_start <= n_start;
            r_tok   <= n_tok;
            r_last  <= n_last;
        end
    end

    assign o_tok  = r_tok;
    assign o_last = r_last;

endmodule

// ===== rtl/key_press_classifier_core.sv =====
`timescale 1ns / 1ps

// Key press classifier. Each scan request carries the tick count, the pin
// levels and an averaged ladder ADC reading; for every request exactly one
// result comes back with at most one pin key event and one ladder key event
// (short or long press) and the key that raised it. Each key has a debounce
// phase machine living in its own cell; a scan token walks the row of cells,
// one cell per clock, from the input register to a holding stage and the
// output register, and a new request is taken only once the previous result
// has left the holding stage. Timing registers are 31-bit tick spans and
// tests are wrap-aware on the 32-bit tick count. Configuration must be
// written only while no scan is in flight; the block does not enforce this.

module key_press_classifier_core
    import kpc_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [WIN_W-1:0] i_cfg_data
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    t_cfg          r_cfg;
    t_scan         r_tok, n_tok;
    logic [KW-1:0] r_last_key;
    logic          r_busy;
    t_out_item     r_pend;
    logic          r_pend_valid;
    t_out_item     r_out;
    logic          r_out_valid;

    t_scan         w_tok  [0:NUM_KEYS];
    logic [KW-1:0] w_last [0:NUM_KEYS];
    logic          w_in_acc;
    logic          w_pend_move;

    assign w_in_acc    = i_in_valid && !r_busy;
    assign w_pend_move = r_pend_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= DEBOUNCE_RST;
            r_cfg.long_press_ticks <= LONG_PRESS_RST;
            r_cfg.ladder_key_mask  <= LADDER_MASK_RST;
            r_cfg.window_lows      <= WIN_LOWS_RST;
            r_cfg.window_highs     <= WIN_HIGHS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:    r_cfg.debounce_ticks   <= i_cfg_data[SPAN_W-1:0];
                CFG_LONG_PRESS:  r_cfg.long_press_ticks <= i_cfg_data[SPAN_W-1:0];
                CFG_LADDER_MASK: r_cfg.ladder_key_mask  <= i_cfg_data[PIN_KEYS-1:0];
                CFG_WIN_LOWS:    r_cfg.window_lows      <= i_cfg_data;
                CFG_WIN_HIGHS:   r_cfg.window_highs     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_tok             = '0;
        n_tok.valid       = w_in_acc;
        n_tok.now_ticks   = i_in_data.now_ticks;
        n_tok.pin_levels  = i_in_data.pin_levels;
        n_tok.adc_average = i_in_data.adc_average;
        n_tok.adc_valid   = i_in_data.adc_valid;
        n_tok.res         = '{EV_NONE, 2'd0, EV_NONE, 2'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign w_tok[0]  = r_tok;
    assign w_last[0] = r_last_key;

    generate
        for (genvar g = 0; g < NUM_KEYS; g++) begin : g_cell
            kpc_cell #(
                .NUM_KEYS (NUM_KEYS),
                .KEY_IDX  (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cfg   (r_cfg),
                .i_tok   (w_tok[g]),
                .i_last  (w_last[g]),
                .o_tok   (w_tok[g+1]),
                .o_last  (w_last[g+1])
            );
        end
    endgenerate

    // scan end holds the result until the output register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_key   <= '0;
        end else begin
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end else if (w_pend_move) begin
                r_busy <= 1'b0;
            end

            if (w_tok[NUM_KEYS].valid) begin
                r_pend_valid <= 1'b1;
                r_last_key   <= w_last[NUM_KEYS];
            end else if (w_pend_move) begin
                r_pend_valid <= 1'b0;
            end

            if (w_pend_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tok[NUM_KEYS].valid) begin
            r_pend <= w_tok[NUM_KEYS].res;
        end
        if (w_pend_move) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
